FILE: rtl/core/cmr_pkg.sv
// shared constants for the can multiframe reassembler
`timescale 1ns / 1ps

package cmr_pkg;

   localparam int NUM_SLOTS   = 4;
   localparam int MAX_LEN     = 64;
   localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int POS_W       = $clog2(MAX_LEN);
   localparam int LEN_W       = POS_W + 1;
   localparam int ADDR_W      = SLOT_W + POS_W;
   localparam int MEM_DEPTH   = NUM_SLOTS * MAX_LEN;
   localparam int CONT_BYTES  = 7;
   localparam int FIRST_BYTES = 3;
   localparam int BYTE_SEL_W  = 3;

   localparam logic [7:0] START_MARKER_RESET = 8'h3a;

   typedef logic [7:0] byte_type;

endpackage

FILE: rtl/core/cmr_req_if.sv
// frame channel carrying one can data frame per item
`timescale 1ns / 1ps

interface cmr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte_0;
   logic [7:0] frame_byte_1;
   logic [7:0] frame_byte_2;
   logic [7:0] frame_byte_3;
   logic [7:0] frame_byte_4;
   logic [7:0] frame_byte_5;
   logic [7:0] frame_byte_6;
   logic [7:0] frame_byte_7;

   modport source (
      output valid, frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3,
             frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7,
      input  ready
   );

   modport sink (
      input  valid, frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3,
             frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7,
      output ready
   );
endinterface

FILE: rtl/core/cmr_rsp_if.sv
// result channel carrying one payload byte of a message per item
`timescale 1ns / 1ps

interface cmr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_id;
   logic [7:0] device_code;
   logic [7:0] command;
   logic [6:0] msg_length;
   logic [5:0] byte_index;
   logic [7:0] payload_byte;
   logic       last;

   modport source (
      output valid, source_id, device_code, command, msg_length, byte_index,
             payload_byte, last,
      input  ready
   );

   modport sink (
      input  valid, source_id, device_code, command, msg_length, byte_index,
             payload_byte, last,
      output ready
   );
endinterface

FILE: rtl/core/can_multiframe_reassembler_unit.sv
// top level of the can multiframe reassembler
//
//   port       dir   handshake        carries
//   req_chan   in    valid / ready    one 8-byte can frame
//   rsp_chan   out   valid / ready    one payload byte of a finished message
//   csr_*      in    write enable     start marker value
//
// a frame is taken in idle and its slot searched in match; a dropped frame ends there,
// a stored one then writes 3 or 7 payload bytes in the write state (one write port)
// a finishing frame then emits max(length,1) results from the payload memory read port,
// one per cycle while rsp is not stalled; the slot frees with the last accepted result
// reset (synchronous) clears slot busy flags and the sequencer; no clearing pass
// rsp stalls hold the output register and the memory read; req waits meanwhile
`timescale 1ns / 1ps

module can_multiframe_reassembler_unit
   import cmr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,
   cmr_req_if.sink      req_chan,
   cmr_rsp_if.source    rsp_chan
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [7:0]            marker_ff;
   byte_type              frame_ff [8];
   logic [NUM_SLOTS-1:0]  busy_ff, busy_in;
   byte_type              sender_ff  [NUM_SLOTS];
   byte_type              device_ff  [NUM_SLOTS];
   byte_type              command_ff [NUM_SLOTS];
   logic [LEN_W-1:0]      length_ff  [NUM_SLOTS];
   logic [LEN_W-1:0]      fill_ff    [NUM_SLOTS];

   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [LEN_W-1:0]      base_ff, base_in;
   logic [BYTE_SEL_W-1:0] src_ff, src_in;
   logic [BYTE_SEL_W-1:0] cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [LEN_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [POS_W-1:0]      out_idx_ff, out_idx_in;
   logic                  out_last_ff, out_last_in;

   byte_type              mem [MEM_DEPTH];
   byte_type              rdata_ff;

   logic                  req_accept;
   logic                  rsp_accept;
   logic                  hit;
   logic [SLOT_W-1:0]     hit_slot;
   logic                  free_any;
   logic [SLOT_W-1:0]     free_slot;
   logic [LEN_W-1:0]      cont_sum;
   logic [LEN_W-1:0]      cont_fill;
   logic [LEN_W-1:0]      start_len;
   logic [LEN_W-1:0]      emit_cnt;
   logic                  meta_we;
   logic                  fill_we;
   logic [LEN_W-1:0]      fill_wdata;
   logic                  mem_we;
   logic                  mem_re;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;

   // lowest busy slot with this sender, lowest free slot
   always_comb begin
      hit       = 1'b0;
      hit_slot  = '0;
      free_any  = 1'b0;
      free_slot = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (busy_ff[s] && (sender_ff[s] == frame_ff[0])) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(s);
         end
         if (!busy_ff[s]) begin
            free_any  = 1'b1;
            free_slot = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      cont_sum  = fill_ff[hit_slot] + LEN_W'(CONT_BYTES);
      cont_fill = (cont_sum > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : cont_sum;
      start_len = (frame_ff[3] > 8'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                              : frame_ff[3][LEN_W-1:0];
      emit_cnt  = (length_ff[slot_ff] == '0) ? LEN_W'(1) : length_ff[slot_ff];
   end

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      base_in      = base_ff;
      src_in       = src_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      rd_idx_in    = rd_idx_ff;
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      meta_we      = 1'b0;
      fill_we      = 1'b0;
      fill_wdata   = cont_fill;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (hit) begin
               slot_in    = hit_slot;
               base_in    = fill_ff[hit_slot];
               src_in     = BYTE_SEL_W'(1);
               cnt_in     = BYTE_SEL_W'(CONT_BYTES);
               done_in    = cont_fill >= length_ff[hit_slot];
               fill_we    = 1'b1;
               fill_wdata = cont_fill;
               state_in   = ST_WRITE;
            end else if ((frame_ff[1] == marker_ff) && free_any) begin
               slot_in            = free_slot;
               base_in            = '0;
               src_in             = BYTE_SEL_W'(5);
               cnt_in             = BYTE_SEL_W'(FIRST_BYTES);
               done_in            = start_len <= LEN_W'(FIRST_BYTES);
               meta_we            = 1'b1;
               fill_we            = 1'b1;
               fill_wdata         = LEN_W'(FIRST_BYTES);
               busy_in[free_slot] = 1'b1;
               state_in           = ST_WRITE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            mem_we  = base_ff < LEN_W'(MAX_LEN);
            base_in = base_ff + LEN_W'(1);
            src_in  = src_ff + BYTE_SEL_W'(1);
            cnt_in  = cnt_ff - BYTE_SEL_W'(1);
            if (cnt_ff == BYTE_SEL_W'(1)) begin
               rd_idx_in    = '0;
               out_valid_in = 1'b0;
               state_in     = done_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_accept) begin
               if (rd_idx_ff < emit_cnt) begin
                  mem_re       = 1'b1;
                  out_valid_in = 1'b1;
                  out_idx_in   = rd_idx_ff[POS_W-1:0];
                  out_last_in  = (rd_idx_ff + LEN_W'(1)) == emit_cnt;
                  rd_idx_in    = rd_idx_ff + LEN_W'(1);
               end else begin
                  out_valid_in     = 1'b0;
                  busy_in[slot_ff] = 1'b0;
                  state_in         = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         out_valid_ff <= 1'b0;
         marker_ff    <= START_MARKER_RESET;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            marker_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      base_ff     <= base_in;
      src_ff      <= src_in;
      cnt_ff      <= cnt_in;
      done_ff     <= done_in;
      rd_idx_ff   <= rd_idx_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
      if (req_accept) begin
         frame_ff[0] <= req_chan.frame_byte_0;
         frame_ff[1] <= req_chan.frame_byte_1;
         frame_ff[2] <= req_chan.frame_byte_2;
         frame_ff[3] <= req_chan.frame_byte_3;
         frame_ff[4] <= req_chan.frame_byte_4;
         frame_ff[5] <= req_chan.frame_byte_5;
         frame_ff[6] <= req_chan.frame_byte_6;
         frame_ff[7] <= req_chan.frame_byte_7;
      end
      if (meta_we) begin
         sender_ff[free_slot]  <= frame_ff[0];
         device_ff[free_slot]  <= frame_ff[2];
         command_ff[free_slot] <= frame_ff[4];
         length_ff[free_slot]  <= start_len;
      end
      if (fill_we) begin
         fill_ff[slot_in] <= fill_wdata;
      end
   end

   // payload memory, one write and one registered read per cycle
   assign wr_addr = {slot_ff, base_ff[POS_W-1:0]};
   assign rd_addr = {slot_ff, rd_idx_ff[POS_W-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= frame_ff[src_ff];
      end
      if (mem_re) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.source_id    = sender_ff[slot_ff];
   assign rsp_chan.device_code  = device_ff[slot_ff];
   assign rsp_chan.command      = command_ff[slot_ff];
   assign rsp_chan.msg_length   = length_ff[slot_ff];
   assign rsp_chan.byte_index   = out_idx_ff;
   assign rsp_chan.payload_byte = (length_ff[slot_ff] == '0) ? 8'h00 : rdata_ff;
   assign rsp_chan.last         = out_last_ff;

endmodule

FILE: rtl/core/cmr_checker.sv
// port-level assertions for the can multiframe reassembler and their bind
`timescale 1ns / 1ps

module cmr_checker
   import cmr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_byte_index,
   input logic       rsp_last
);

   // no new frame is taken while a message is streaming
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("frame accepted while a result is pending");

   // a frame is worked on before the next one is taken
   a_req_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a frame was accepted");

   // a message streams without gaps and in byte order
   a_rsp_next_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && (rsp_byte_index == $past(rsp_byte_index) + 6'd1)))
      else $error("message byte missing or out of order");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind can_multiframe_reassembler_unit cmr_checker u_cmr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_byte_index (rsp_chan.byte_index),
   .rsp_last       (rsp_chan.last)
);
